>>> src/cbax_pkg.sv
// ----------------------------------------------------------------------------
// cbax_pkg
// shared types, constants and bit helpers for the cursor row converter
// ----------------------------------------------------------------------------
`default_nettype none

package cbax_pkg;

    localparam int WORD_W    = 16;
    localparam int ROW_BITS  = 64;
    localparam int ROW_WORDS = ROW_BITS / WORD_W;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int WCNT_W    = 6;
    localparam int ROW_W     = 6;
    localparam int WPR_MAX   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WPR    = 2'd1;

    localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;
    localparam logic [CFG_W-1:0] WPR_RESET    = 7'd4;

    // controller to datapath
    typedef struct packed {
        logic take_word;
        logic load_pad;
    } cbax_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic row_done;
        logic pad_start;
        logic last_pad;
    } cbax_sts_t;

    // reverse the bits of each byte separately
    function automatic logic [WORD_W-1:0] flip_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i]     = w[7-i];
            r[8+i]   = w[15-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/cursor_bitmap_to_and_xor_rows.sv
// ----------------------------------------------------------------------------
// cursor_bitmap_to_and_xor_rows
// monochrome cursor words to 64-bit AND/XOR image rows
// ----------------------------------------------------------------------------
// one word transfer per cycle while the output register is free
// a word that ends a row shows that row on the outputs in the next cycle
// after the last source row, padding rows follow one per cycle while the output is free; input waits
// throughput set by the single output register and the padding sequencer
// reset: counters cleared, accumulators AND ones / XOR zero, height 64, 4 words
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_bitmap_to_and_xor_rows
    import cbax_pkg::*;
#(
    parameter int CURSOR_SIZE = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [WORD_W-1:0]    mask_word,
    input  wire logic [WORD_W-1:0]    source_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ROW_BITS-1:0]       and_row,
    output logic [ROW_BITS-1:0]       xor_row,
    output logic [ROW_W-1:0]          row_index,
    output logic                      last_row
);

    cbax_cmd_t cmd;
    cbax_sts_t sts;

    assign cfg_ready = 1'b1;

    cbax_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cbax_dp #(
        .CURSOR_SIZE (CURSOR_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mask_word   (mask_word),
        .source_word (source_word),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .and_row     (and_row),
        .xor_row     (xor_row),
        .row_index   (row_index),
        .last_row    (last_row)
    );

endmodule

`default_nettype wire

>>> src/cbax_ctrl.sv
// ----------------------------------------------------------------------------
// cbax_ctrl
// sequencer: takes words while a row is built, then issues padding rows
// ----------------------------------------------------------------------------
`default_nettype none

module cbax_ctrl
    import cbax_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cbax_sts_t sts,
    output cbax_cmd_t      cmd
);

    localparam logic S_RUN = 1'b0;
    localparam logic S_PAD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign in_ready      = (state_reg == S_RUN) && sts.out_free;
    assign accept        = in_valid && in_ready;
    assign cmd.take_word = accept;
    assign cmd.load_pad  = (state_reg == S_PAD) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_RUN:
            begin
                if (accept && sts.row_done && sts.pad_start)
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                if (cmd.load_pad && sts.last_pad)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take_word && cmd.load_pad))
        else $error("word transfer and padding row in same cycle");

    a_pad_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD) |-> !in_ready)
        else $error("input ready while padding rows are pending");

    a_pad_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sts.row_done && sts.pad_start) |=> (state_reg == S_PAD))
        else $error("padding not started after last source row");

endmodule

`default_nettype wire

>>> src/cbax_dp.sv
// ----------------------------------------------------------------------------
// cbax_dp
// datapath: config registers, row accumulators, counters, output register
// ----------------------------------------------------------------------------
`default_nettype none

module cbax_dp
    import cbax_pkg::*;
#(
    parameter int CURSOR_SIZE = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [WORD_W-1:0]    mask_word,
    input  wire logic [WORD_W-1:0]    source_word,
    input  wire cbax_cmd_t            cmd,
    output cbax_sts_t                 sts,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ROW_BITS-1:0]       and_row,
    output logic [ROW_BITS-1:0]       xor_row,
    output logic [ROW_W-1:0]          row_index,
    output logic                      last_row
);

    localparam int WORDS_USED = CURSOR_SIZE / WORD_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CURSOR_SIZE - 1);
    localparam logic [CFG_W-1:0] SIZE_CFG = CFG_W'(CURSOR_SIZE);
    localparam logic [CFG_W-1:0] WPR_CFG  = CFG_W'(WPR_MAX);

    logic [CFG_W-1:0]    height_reg;
    logic [CFG_W-1:0]    wpr_reg;
    logic [CFG_W-1:0]    height_eff;
    logic [CFG_W-1:0]    wpr_eff;
    logic [WCNT_W-1:0]   word_count_reg;
    logic [ROW_W-1:0]    row_count_reg;
    logic [ROW_BITS-1:0] and_accum_reg;
    logic [ROW_BITS-1:0] xor_accum_reg;
    logic [ROW_BITS-1:0] and_merge;
    logic [ROW_BITS-1:0] xor_merge;
    logic [WORD_W-1:0]   m_flip;
    logic [WORD_W-1:0]   s_flip;
    logic [CFG_W-1:0]    wc_inc;
    logic [CFG_W-1:0]    rc_inc;
    logic                row_last;
    logic [ROW_W-1:0]    row_count_adv;
    logic                out_valid_reg;
    logic [ROW_BITS-1:0] and_row_reg;
    logic [ROW_BITS-1:0] xor_row_reg;
    logic [ROW_W-1:0]    row_index_reg;
    logic                last_row_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            wpr_reg    <= WPR_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            else if (cfg_index == CFG_WPR)
            begin
                wpr_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        priority if (height_reg == '0)
            height_eff = CFG_W'(1);
        else if (height_reg > SIZE_CFG)
            height_eff = SIZE_CFG;
        else
            height_eff = height_reg;

        priority if (wpr_reg == '0)
            wpr_eff = CFG_W'(1);
        else if (wpr_reg > WPR_CFG)
            wpr_eff = WPR_CFG;
        else
            wpr_eff = wpr_reg;
    end

    // word merge into the row being built
    assign m_flip = flip_word(mask_word);
    assign s_flip = flip_word(source_word);

    always_comb
    begin
        and_merge = and_accum_reg;
        xor_merge = xor_accum_reg;
        for (int k = 0; k < ROW_WORDS; k++)
        begin
            if ((k < WORDS_USED) && (word_count_reg == WCNT_W'(k)))
            begin
                and_merge[k*WORD_W +: WORD_W] = ~m_flip;
                xor_merge[k*WORD_W +: WORD_W] = s_flip & m_flip;
            end
        end
    end

    assign wc_inc        = CFG_W'(word_count_reg) + CFG_W'(1);
    assign rc_inc        = CFG_W'(row_count_reg) + CFG_W'(1);
    assign row_last      = (row_count_reg == LAST_ROW);
    assign row_count_adv = row_last ? '0 : ROW_W'(rc_inc);

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.row_done  = (wc_inc >= wpr_eff);
    assign sts.pad_start = (rc_inc >= height_eff) && !row_last;
    assign sts.last_pad  = row_last;

    // row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            row_count_reg  <= '0;
            and_accum_reg  <= '1;
            xor_accum_reg  <= '0;
        end
        else if (cmd.take_word)
        begin
            if (sts.row_done)
            begin
                word_count_reg <= '0;
                row_count_reg  <= row_count_adv;
                and_accum_reg  <= '1;
                xor_accum_reg  <= '0;
            end
            else
            begin
                word_count_reg <= WCNT_W'(wc_inc);
                and_accum_reg  <= and_merge;
                xor_accum_reg  <= xor_merge;
            end
        end
        else if (cmd.load_pad)
        begin
            row_count_reg <= row_count_adv;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.take_word && sts.row_done) || cmd.load_pad)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_word && sts.row_done)
        begin
            and_row_reg   <= and_merge;
            xor_row_reg   <= xor_merge;
            row_index_reg <= row_count_reg;
            last_row_reg  <= row_last;
        end
        else if (cmd.load_pad)
        begin
            and_row_reg   <= '1;
            xor_row_reg   <= '0;
            row_index_reg <= row_count_reg;
            last_row_reg  <= row_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign and_row   = and_row_reg;
    assign xor_row   = xor_row_reg;
    assign row_index = row_index_reg;
    assign last_row  = last_row_reg;

    a_pad_content: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_pad |=> (and_row_reg == '1) && (xor_row_reg == '0))
        else $error("padding row not all ones and zero");

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_word && sts.row_done) |=> (word_count_reg == '0) && out_valid_reg)
        else $error("finished row not emitted or word count not cleared");

    a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_pad && row_last) |=> (row_count_reg == '0))
        else $error("row count did not wrap after last row");

endmodule

`default_nettype wire
